/* sv/gmtb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmtb_pkg: shared types and codes of the gated multi timer bank
// Command and event codes, channel states and the channel record that the
// channel store keeps for each timer channel.
// ----------------------------------------------------------------------------
package gmtb_pkg;

    // command codes
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_LOAD  = 3'd1;
    localparam logic [2:0] CMD_START = 3'd2;
    localparam logic [2:0] CMD_STOP  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // event kinds
    localparam logic [1:0] EV_EXPIRE = 2'd0;
    localparam logic [1:0] EV_TICK   = 2'd1;
    localparam logic [1:0] EV_ACK    = 2'd2;

    // channel run states
    localparam logic [1:0] ST_OFF  = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // saturation bounds of the Q16.16 timer, in the width of the raw sum
    localparam logic signed [41:0] SUM_MAX = 42'sd2147483647;
    localparam logic signed [41:0] SUM_MIN = -42'sd2147483648;

    // one channel of the store
    typedef struct packed {
        logic signed [31:0] timer;
        logic signed [31:0] end_val;
        logic signed [15:0] rate;
        logic [31:0]        mask;
        logic [1:0]         state;
        logic [31:0]        tag_a;
        logic [31:0]        tag_b;
    } chan_rec_t;

    // outcome of one channel update on a tick
    typedef struct packed {
        logic               go;
        logic               hit;
        logic signed [31:0] timer;
    } step_res_t;

endpackage

`default_nettype wire

/* sv/gmtb_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmtb_if: valid/ready channels of the timer bank
// gmtb_cmd_if carries command beats into the bank, gmtb_evt_if carries
// event beats out of it.
// ----------------------------------------------------------------------------
interface gmtb_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [3:0]         clock_index;
    logic signed [31:0] start_value;
    logic signed [31:0] end_value;
    logic signed [15:0] rate;
    logic [31:0]        active_mask;
    logic [31:0]        tag_first;
    logic [31:0]        tag_second;
    logic [31:0]        delta_t;
    logic [31:0]        current_mode;

    modport source (
        output valid, command, clock_index, start_value, end_value, rate,
               active_mask, tag_first, tag_second, delta_t, current_mode,
        input  ready
    );
    modport sink (
        input  valid, command, clock_index, start_value, end_value, rate,
               active_mask, tag_first, tag_second, delta_t, current_mode,
        output ready
    );
endinterface

interface gmtb_evt_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_kind;
    logic [3:0]         channel;
    logic signed [31:0] timer_value;
    logic [1:0]         run_state;
    logic [31:0]        user_word_a;
    logic [31:0]        user_word_b;
    logic               last;

    modport source (
        output valid, event_kind, channel, timer_value, run_state,
               user_word_a, user_word_b, last,
        input  ready
    );
    modport sink (
        input  valid, event_kind, channel, timer_value, run_state,
               user_word_a, user_word_b, last,
        output ready
    );
endinterface

`default_nettype wire

/* sv/gmtb_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmtb_store: channel record memory
// One write port and one read port with registered read data. A valid bit
// per channel, cleared by reset, makes a never written channel read as zero.
// ----------------------------------------------------------------------------
module gmtb_store import gmtb_pkg::*; #(
    parameter int CHANNELS = 16,
    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic [IW-1:0] rd_addr,
    output chan_rec_t      rd_data,
    input  wire logic      wr_en,
    input  wire logic [IW-1:0] wr_addr,
    input  wire chan_rec_t wr_data
);

    chan_rec_t             mem [CHANNELS];
    chan_rec_t             rd_raw_reg;
    logic [CHANNELS-1:0]   valid_reg;
    logic                  rd_valid_reg;

    // memory array, read before write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_raw_reg <= mem[rd_addr];
    end

    // written flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // unwritten channels read as the reset record
    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule

`default_nettype wire

/* sv/gmtb_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmtb_step: tick update of one channel
// Takes the registered Q24.24 product delta_t * rate, floors it to Q16.16,
// adds it with saturation and tests expiry against the end value.
// ----------------------------------------------------------------------------
module gmtb_step import gmtb_pkg::*; (
    input  wire chan_rec_t          rec,
    input  wire logic signed [48:0] prod,
    input  wire logic [31:0]        mode,
    output step_res_t               res
);

    logic signed [40:0] step;
    logic signed [41:0] sum;
    logic signed [31:0] sat;
    logic               hit;

    // floor shift to Q16.16 and saturating add
    always_comb
    begin
        step = 41'(prod >>> 8);
        sum  = 42'(rec.timer) + 42'(step);
        if (sum > SUM_MAX)
        begin
            sat = 32'sh7fffffff;
        end
        else if (sum < SUM_MIN)
        begin
            sat = 32'sh80000000;
        end
        else
        begin
            sat = 32'(sum);
        end
    end

    // expiry direction follows the sign of the rate
    assign hit = rec.rate[15] ? (sat <= rec.end_val) : (sat >= rec.end_val);

    assign res.go    = (rec.state == ST_RUN) && ((rec.mask & mode) != 32'd0);
    assign res.hit   = hit;
    assign res.timer = hit ? rec.end_val : sat;

endmodule

`default_nettype wire

/* sv/gated_multi_timer_bank.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gated_multi_timer_bank: bank of mode gated timer channels
// Command beats come in on cmd, event beats leave on evt, both valid/ready.
// Load, start, stop and read each answer with one acknowledge beat holding
// the channel after the command. A tick walks the channels through a three
// stage read, multiply, update pipeline over the channel memory, one
// channel per cycle while the walk is not held, and emits an expiry beat
// for each channel that reaches its end value, then a tick finished beat
// with last set. One command is handled at a time; cmd.ready is high only
// while the bank is idle, even while an event beat waits in the output
// register. When evt is stalled the walk holds at the first expiring
// channel that finds the output register full and resumes once the waiting
// beat is taken. Reset clears all channels to off with zero contents at
// once; no clearing pass is needed. Commands with an unused code, and
// channel commands with a channel index at or above CHANNELS, are dropped
// without an answer.
// ----------------------------------------------------------------------------
module gated_multi_timer_bank import gmtb_pkg::*; #(
    parameter int CHANNELS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    gmtb_cmd_if.sink    cmd,
    gmtb_evt_if.source  evt
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = $clog2(CHANNELS + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_WALK   = 5'b00010,
        S_FINISH = 5'b00100,
        S_READ   = 5'b01000,
        S_REPLY  = 5'b10000
    } fsm_t;

    fsm_t               state_reg, state_next;

    // held command
    logic [2:0]         cmd_reg;
    logic [IW-1:0]      cmd_ch_reg;
    chan_rec_t          ld_rec_reg;
    logic [31:0]        dt_reg;
    logic [31:0]        mode_reg;

    // tick walk pipeline
    logic [CW-1:0]      issue_cnt_reg, issue_cnt_next;
    logic               p1_valid_reg, p1_valid_next;
    logic [IW-1:0]      p1_ch_reg;
    logic               p2_valid_reg, p2_valid_next;
    logic [IW-1:0]      p2_ch_reg;
    chan_rec_t          p2_rec_reg;
    logic signed [48:0] prod_reg;
    logic signed [48:0] prod_next;
    logic               issuing;
    logic [IW-1:0]      issue_idx;
    logic               advance;
    step_res_t          res;

    // memory ports
    logic [IW-1:0]      rd_addr;
    chan_rec_t          rd_data;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    chan_rec_t          wr_data;

    // output register
    logic               out_valid_reg;
    logic               out_free;
    logic               out_load;
    logic [1:0]         out_kind_next, out_kind_reg;
    logic [IW-1:0]      out_ch_next, out_ch_reg;
    chan_rec_t          out_rec_next, out_rec_reg;

    logic               accept;
    logic               in_range;
    chan_rec_t          reply_rec;

    gmtb_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    gmtb_step u_step (
        .rec  (p2_rec_reg),
        .prod (prod_reg),
        .mode (mode_reg),
        .res  (res)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign in_range  = 9'(cmd.clock_index) < 9'(CHANNELS);
    assign out_free  = !out_valid_reg || evt.ready;

    assign issuing   = issue_cnt_reg < CW'(CHANNELS);
    assign issue_idx = issue_cnt_reg[IW-1:0];
    // the walk holds while an expiry beat has nowhere to go
    assign advance   = !(p2_valid_reg && res.go && res.hit && !out_free);
    assign prod_next = 49'($signed({1'b0, dt_reg})) * 49'(rd_data.rate);

    // acknowledge record of a channel command
    always_comb
    begin
        reply_rec = rd_data;
        unique case (cmd_reg)
            CMD_LOAD:  reply_rec = ld_rec_reg;
            CMD_START: reply_rec.state = ST_RUN;
            CMD_STOP:  reply_rec.state = ST_OFF;
            default:   reply_rec = rd_data;
        endcase
    end

    // sequencer, memory ports and output beat selection
    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        p1_valid_next  = p1_valid_reg;
        p2_valid_next  = p2_valid_reg;
        rd_addr        = cmd_ch_reg;
        wr_en          = 1'b0;
        wr_addr        = p2_ch_reg;
        wr_data        = p2_rec_reg;
        out_load       = 1'b0;
        out_kind_next  = EV_ACK;
        out_ch_next    = cmd_ch_reg;
        out_rec_next   = reply_rec;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.command)
                        CMD_TICK:
                        begin
                            state_next     = S_WALK;
                            issue_cnt_next = '0;
                            p1_valid_next  = 1'b0;
                            p2_valid_next  = 1'b0;
                        end
                        CMD_LOAD:
                        begin
                            if (in_range)
                            begin
                                state_next = S_REPLY;
                            end
                        end
                        CMD_START, CMD_STOP, CMD_READ:
                        begin
                            if (in_range)
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                rd_addr = (advance && issuing) ? issue_idx : p1_ch_reg;
                if (advance)
                begin
                    issue_cnt_next = issue_cnt_reg + CW'(issuing);
                    p1_valid_next  = issuing;
                    p2_valid_next  = p1_valid_reg;
                    if (p2_valid_reg && res.go)
                    begin
                        wr_en         = 1'b1;
                        wr_data.timer = res.timer;
                        wr_data.state = res.hit ? ST_DONE : ST_RUN;
                        if (res.hit)
                        begin
                            out_load      = 1'b1;
                            out_kind_next = EV_EXPIRE;
                            out_ch_next   = p2_ch_reg;
                            out_rec_next  = wr_data;
                        end
                    end
                end
                if (!issuing && !p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                out_kind_next = EV_TICK;
                out_ch_next   = '0;
                out_rec_next  = '0;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_READ:
            begin
                state_next = S_REPLY;
            end

            S_REPLY:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    wr_en      = (cmd_reg != CMD_READ);
                    wr_addr    = cmd_ch_reg;
                    wr_data    = reply_rec;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_cnt_reg <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (evt.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // command capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg            <= cmd.command;
            cmd_ch_reg         <= IW'(cmd.clock_index);
            dt_reg             <= cmd.delta_t;
            mode_reg           <= cmd.current_mode;
            ld_rec_reg.timer   <= cmd.start_value;
            ld_rec_reg.end_val <= cmd.end_value;
            ld_rec_reg.rate    <= cmd.rate;
            ld_rec_reg.mask    <= cmd.active_mask;
            ld_rec_reg.state   <= ST_OFF;
            ld_rec_reg.tag_a   <= cmd.tag_first;
            ld_rec_reg.tag_b   <= cmd.tag_second;
        end
    end

    // walk pipeline data
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WALK && advance)
        begin
            p1_ch_reg  <= issue_idx;
            p2_ch_reg  <= p1_ch_reg;
            p2_rec_reg <= rd_data;
            prod_reg   <= prod_next;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg <= out_kind_next;
            out_ch_reg   <= out_ch_next;
            out_rec_reg  <= out_rec_next;
        end
    end

    assign evt.valid       = out_valid_reg;
    assign evt.event_kind  = out_kind_reg;
    assign evt.channel     = 4'(out_ch_reg);
    assign evt.timer_value = out_rec_reg.timer;
    assign evt.run_state   = out_rec_reg.state;
    assign evt.user_word_a = out_rec_reg.tag_a;
    assign evt.user_word_b = out_rec_reg.tag_b;
    assign evt.last        = (out_kind_reg != EV_EXPIRE);

    // store is only written while a command is in progress
    a_no_write_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en
    ) else $error("channel store written while idle");

    // the walk never issues past the last channel
    a_issue_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        issue_cnt_reg <= CW'(CHANNELS)
    ) else $error("tick walk issued beyond the last channel");

    // a stalled walk keeps its update stage
    a_walk_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && !advance) |=> $stable(p2_ch_reg) && p2_valid_reg
    ) else $error("tick walk moved while stalled");

    // an event beat is only loaded into a free output register
    a_out_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_load |-> out_free
    ) else $error("event beat overwritten before it was taken");

    // the finishing beat returns the bank to idle
    a_finish_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_free) |=> (state_reg == S_IDLE) && out_valid_reg
    ) else $error("tick did not complete after its finishing beat");

endmodule

`default_nettype wire

/* verif/timer_bank_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_bank_checker: event predictor and comparator for the timer bank
// Watches the command and event channels. Every accepted command beat is
// applied to a private copy of the channel bank, which queues the event
// beats it should cause; every accepted event beat is compared with the
// oldest queued one.
// ----------------------------------------------------------------------------
module timer_bank_checker import gmtb_pkg::*; #(
    parameter int CHANNELS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gmtb_cmd_if       cmd,
    gmtb_evt_if       evt,
    output int        errors,
    output int        waiting,
    output int        expiries,
    output int        ticks
);

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         channel;
        logic signed [31:0] value;
        logic [1:0]         run_state;
        logic [31:0]        word_a;
        logic [31:0]        word_b;
        logic               last;
    } evt_beat_t;

    chan_rec_t bank [CHANNELS];
    evt_beat_t due_events [$];
    int        mismatches = 0;
    int        expiry_count = 0;
    int        tick_count = 0;
    int        due_count = 0;

    assign errors   = mismatches;
    assign waiting  = due_count;
    assign expiries = expiry_count;
    assign ticks    = tick_count;

    // timer value after one gated tick: Q24.24 product floored to Q16.16, saturated sum
    function automatic logic signed [31:0] stepped_value(input logic signed [31:0] value,
                                                         input logic [31:0] dt,
                                                         input logic signed [15:0] slope);
        logic signed [63:0] product;
        logic signed [63:0] total;
        product = $signed({32'd0, dt}) * slope;
        total   = value + (product >>> 8);
        if (total > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (total < -64'sd2147483648)
            return 32'sh8000_0000;
        return total[31:0];
    endfunction

    // beat that reports the current contents of one channel
    function automatic evt_beat_t channel_beat(input logic [1:0] kind, input int ch,
                                               input logic last);
        evt_beat_t b;
        b.kind      = kind;
        b.channel   = ch[3:0];
        b.value     = bank[ch].timer;
        b.run_state = bank[ch].state;
        b.word_a    = bank[ch].tag_a;
        b.word_b    = bank[ch].tag_b;
        b.last      = last;
        return b;
    endfunction

    // walk the bank in index order, expiring channels that reach their end value
    task automatic advance_bank(input logic [31:0] dt, input logic [31:0] mode);
        logic signed [31:0] value;
        logic signed [31:0] limit;
        logic signed [15:0] slope;
        logic               hit;
        evt_beat_t          done_beat;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if (bank[ch].state != ST_RUN || (bank[ch].mask & mode) == '0)
                continue;
            slope = bank[ch].rate;
            limit = bank[ch].end_val;
            value = stepped_value(bank[ch].timer, dt, slope);
            hit   = (slope >= 0) ? (value >= limit) : (value <= limit);
            bank[ch].timer = value;
            if (hit)
            begin
                bank[ch].state = ST_DONE;
                bank[ch].timer = limit;
                due_events.push_back(channel_beat(EV_EXPIRE, ch, 1'b0));
            end
        end
        done_beat = '0;
        done_beat.kind = EV_TICK;
        done_beat.last = 1'b1;
        due_events.push_back(done_beat);
    endtask

    // load, start, stop and read each answer with the channel after the command
    task automatic apply_command();
        int ch;
        ch = int'(cmd.clock_index);
        if (ch >= CHANNELS)
            return;
        case (cmd.command)
            CMD_LOAD:
            begin
                bank[ch].timer   = cmd.start_value;
                bank[ch].end_val = cmd.end_value;
                bank[ch].rate    = cmd.rate;
                bank[ch].mask    = cmd.active_mask;
                bank[ch].tag_a   = cmd.tag_first;
                bank[ch].tag_b   = cmd.tag_second;
                bank[ch].state   = ST_OFF;
            end
            CMD_START: bank[ch].state = ST_RUN;
            CMD_STOP:  bank[ch].state = ST_OFF;
            CMD_READ:  ;
            default:   return;
        endcase
        due_events.push_back(channel_beat(EV_ACK, ch, 1'b1));
    endtask

    // predict on command beats, compare on event beats
    always @(posedge clk or negedge rst_n)
    begin
        evt_beat_t got;
        evt_beat_t want;
        if (!rst_n)
        begin
            foreach (bank[i])
                bank[i] = '0;
            due_events.delete();
            due_count <= 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                if (cmd.command == CMD_TICK)
                    advance_bank(cmd.delta_t, cmd.current_mode);
                else
                    apply_command();
            end
            if (evt.valid && evt.ready)
            begin
                got = {evt.event_kind, evt.channel, evt.timer_value, evt.run_state,
                       evt.user_word_a, evt.user_word_b, evt.last};
                if (got.kind == EV_EXPIRE)
                    expiry_count++;
                if (got.kind == EV_TICK)
                    tick_count++;
                if (due_events.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: event beat with nothing due: kind %0d ch %0d value %h",
                                 $realtime, got.kind, got.channel, got.value);
                    mismatches++;
                end
                else
                begin
                    want = due_events.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: event beat differs", $realtime);
                            $display("  expected kind %0d ch %0d value %h state %0d a %h b %h last %0b",
                                     want.kind, want.channel, want.value, want.run_state,
                                     want.word_a, want.word_b, want.last);
                            $display("  actual   kind %0d ch %0d value %h state %0d a %h b %h last %0b",
                                     got.kind, got.channel, got.value, got.run_state,
                                     got.word_a, got.word_b, got.last);
                        end
                        mismatches++;
                    end
                end
            end
            due_count <= due_events.size();
        end
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the gated multi timer bank
// Drives a directed pass over saturation, rounding, zero rate, mode gating
// and state changes, then a random mix of loads, starts, stops, reads,
// unused codes and ticks with random idling on both channels and one long event stall.
// ----------------------------------------------------------------------------
module tb;
    import gmtb_pkg::*;

    localparam int CHANNELS    = 16;
    localparam int ITEMS       = 350;
    localparam int QUIET_TAIL  = 60;
    localparam int HOLD_AT     = 70;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN       = 2 * CHANNELS + 10;
    localparam int LIMIT       = 400000;

    typedef struct packed {
        logic [2:0]         op;
        logic [3:0]         chan;
        logic signed [31:0] start_val;
        logic signed [31:0] end_val;
        logic signed [15:0] rate;
        logic [31:0]        mask;
        logic [31:0]        tag_a;
        logic [31:0]        tag_b;
        logic [31:0]        dt;
        logic [31:0]        mode;
    } cmd_beat_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   waiting;
    int   expiries;
    int   ticks;
    int   sent = 0;
    int   cycles = 0;
    bit   quiet = 1'b0;
    bit   held_off = 1'b0;

    gmtb_cmd_if cmd_ch ();
    gmtb_evt_if evt_ch ();

    gated_multi_timer_bank #(
        .CHANNELS (CHANNELS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .evt   (evt_ch)
    );

    timer_bank_checker #(
        .CHANNELS (CHANNELS)
    ) bank_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_ch),
        .evt      (evt_ch),
        .errors   (errors),
        .waiting  (waiting),
        .expiries (expiries),
        .ticks    (ticks)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("timeout after %0d cycles, %0d event beats still due", cycles, waiting);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // every field random but the command, a read, so each bit of the other fields gets exercised
    function automatic cmd_beat_t noise_beat();
        cmd_beat_t b;
        b.op        = CMD_READ;
        b.chan      = 4'($urandom_range(0, CHANNELS - 1));
        b.start_val = $urandom();
        b.end_val   = $urandom();
        b.rate      = 16'($urandom_range(0, 16'hFFFF));
        b.mask      = $urandom();
        b.tag_a     = $urandom();
        b.tag_b     = $urandom();
        b.dt        = $urandom();
        b.mode      = $urandom();
        return b;
    endfunction

    // mostly well-formed traffic that lets channels run to expiry
    function automatic cmd_beat_t random_command();
        cmd_beat_t b;
        int        pick;
        logic [31:0] span;
        b    = noise_beat();
        pick = $urandom_range(0, 99);
        if (pick < 34)
        begin
            b.op = CMD_TICK;
            if ($urandom_range(0, 4) != 0)
                b.dt = $urandom_range(0, 32'h0004_0000);
            case ($urandom_range(0, 3))
                0:       b.mode = '1;
                1:       b.mode = 32'd1 << $urandom_range(0, 31);
                default: ;
            endcase
        end
        else if (pick < 56)
        begin
            b.op = CMD_LOAD;
            // a quarter of the loads keep fully random contents
            if ($urandom_range(0, 3) != 0)
            begin
                b.rate = 16'($urandom_range(1, 1024));
                if ($urandom_range(0, 1) == 1)
                    b.rate = -b.rate;
                if ($urandom_range(0, 9) == 0)
                    b.rate = '0;
                b.start_val = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
                span        = $urandom_range(0, 32'h0040_0000);
                b.end_val   = (b.rate < 0) ? b.start_val - span : b.start_val + span;
                if ($urandom_range(0, 2) == 0)
                    b.mask = 32'd1 << $urandom_range(0, 31);
                else if ($urandom_range(0, 2) == 0)
                    b.mask = '1;
            end
        end
        else if (pick < 76)
            b.op = CMD_START;
        else if (pick < 82)
            b.op = CMD_STOP;
        else if (pick < 94)
            b.op = CMD_READ;
        else
            b.op = CMD_READ + 3'($urandom_range(1, 3));
        return b;
    endfunction

    // offer one command beat and wait until it is taken
    task automatic issue(input cmd_beat_t b);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= b.op;
        cmd_ch.clock_index  <= b.chan;
        cmd_ch.start_value  <= b.start_val;
        cmd_ch.end_value    <= b.end_val;
        cmd_ch.rate         <= b.rate;
        cmd_ch.active_mask  <= b.mask;
        cmd_ch.tag_first    <= b.tag_a;
        cmd_ch.tag_second   <= b.tag_b;
        cmd_ch.delta_t      <= b.dt;
        cmd_ch.current_mode <= b.mode;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic load_channel(input logic [3:0] ch, input logic [31:0] sv,
                                input logic [31:0] ev, input logic [15:0] r,
                                input logic [31:0] m, input logic [31:0] ta,
                                input logic [31:0] tbw);
        cmd_beat_t b;
        b           = noise_beat();
        b.op        = CMD_LOAD;
        b.chan      = ch;
        b.start_val = sv;
        b.end_val   = ev;
        b.rate      = r;
        b.mask      = m;
        b.tag_a     = ta;
        b.tag_b     = tbw;
        issue(b);
    endtask

    task automatic channel_op(input logic [2:0] op, input logic [3:0] ch);
        cmd_beat_t b;
        b      = noise_beat();
        b.op   = op;
        b.chan = ch;
        issue(b);
    endtask

    task automatic send_tick(input logic [31:0] dt, input logic [31:0] mode);
        cmd_beat_t b;
        b      = noise_beat();
        b.op   = CMD_TICK;
        b.dt   = dt;
        b.mode = mode;
        issue(b);
    endtask

    // event side: short random stalls, one long hold-off, none at the end
    initial
    begin : evt_sink
        evt_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!held_off && sent >= HOLD_AT)
            begin
                // long stall so the bank backs up into the command side
                held_off = 1'b1;
                evt_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                evt_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                evt_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // command side: reset, directed pass, random mix, drain, verdict
    initial
    begin : stimulus
        cmd_beat_t b;
        int        useful;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.command      <= CMD_READ;
        cmd_ch.clock_index  <= '0;
        cmd_ch.start_value  <= '0;
        cmd_ch.end_value    <= '0;
        cmd_ch.rate         <= '0;
        cmd_ch.active_mask  <= '0;
        cmd_ch.tag_first    <= '0;
        cmd_ch.tag_second   <= '0;
        cmd_ch.delta_t      <= '0;
        cmd_ch.current_mode <= '0;
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // untouched channel, then an empty tick
        channel_op(CMD_READ, 4'd0);
        send_tick('0, '0);
        // saturation at the top of the range
        load_channel(4'd0, 32'h7FFF_0000, 32'h7FFF_FFFF, 16'h7FFF, '1, '1, '1);
        channel_op(CMD_START, 4'd0);
        send_tick('1, '1);
        // saturation at the bottom with the most negative rate
        load_channel(4'd1, 32'h8000_0000, 32'h8000_0000, 16'h8000, 32'h1, '0, '0);
        channel_op(CMD_START, 4'd1);
        send_tick('1, 32'h1);
        // zero rate: at the end value expires at once, below it never does
        load_channel(4'd2, 32'h0005_0000, 32'h0005_0000, '0, 32'h2, $urandom(), $urandom());
        channel_op(CMD_START, 4'd2);
        load_channel(4'd3, '0, 32'h0001_0000, '0, 32'h2, $urandom(), $urandom());
        channel_op(CMD_START, 4'd3);
        // channel 4 is gated out by the mode
        load_channel(4'd4, '0, 32'h0010_0000, 16'h0100, 32'h4, $urandom(), $urandom());
        channel_op(CMD_START, 4'd4);
        send_tick(32'h0001_0000, 32'h2);
        channel_op(CMD_READ, 4'd4);
        // tiny negative step rounds toward minus infinity
        load_channel(4'd5, '0, 32'hFC18_0000, 16'hFFFF, 32'h8, $urandom(), $urandom());
        channel_op(CMD_START, 4'd5);
        send_tick(32'd1, 32'h8);
        channel_op(CMD_READ, 4'd5);
        // start while running, stop, restart a done channel
        channel_op(CMD_START, 4'd5);
        channel_op(CMD_STOP, 4'd5);
        channel_op(CMD_START, 4'd0);
        send_tick('0, '1);
        // unused codes on the top channel, then a load there
        for (int c = int'(CMD_READ) + 1; c < 8; c++)
            channel_op(3'(c), 4'd15);
        load_channel(4'd15, $urandom(), $urandom(), 16'h1234, '1, $urandom(), $urandom());

        useful = 0;
        while (useful < ITEMS)
        begin
            if (ITEMS - useful <= QUIET_TAIL)
                quiet = 1'b1;
            b = random_command();
            issue(b);
            if (b.op <= CMD_READ)
                useful++;
        end
        cmd_ch.valid <= 1'b0;

        do
            @(posedge clk);
        while (waiting != 0);
        repeat (DRAIN) @(posedge clk);

        $display("ran %0d command beats in %0d cycles", sent, cycles);
        $display("saw %0d expiry events and %0d tick completions", expiries, ticks);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
sv/gmtb_pkg.sv
sv/gmtb_if.sv
sv/gmtb_store.sv
sv/gmtb_step.sv
sv/gated_multi_timer_bank.sv
verif/timer_bank_checker.sv
verif/tb.sv
